// ===== hdl/sha1_message_digest_top_defines.svh =====
// Assertion helpers for the SHA-1 digest engine.
`ifndef SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/smd_pkg.sv =====
package smd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_C_START,
    ST_C_B,
    ST_C_C,
    ST_C_FIN,
    ST_DONE
  } smd_state_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [3:0] LEN_HI_IDX  = 4'd14;
  localparam logic [3:0] LEN_LO_IDX  = 4'd15;
  localparam logic [6:0] LAST_ROUND  = 7'd79;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

// ===== hdl/sha1_message_digest_top.sv =====
// Operation: message bytes are accepted only in the idle state; input stalls while a block is
// compressed (80 rounds through the two-port block memory, plus load and add).
// Last item: byte-wise padding, two length writes, one or two compressions, then the
// digest register loads.
// Reset (rst_n low, synchronous): chaining words to the initial values, counters
// cleared, no digest pending. The block memory holds no reset.
`include "sha1_message_digest_top_defines.svh"

module sha1_message_digest_top
  import smd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] byte_valid
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // [31:0] digest_word_0 .. [159:128] digest_word_4
);

  smd_state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0] blk_mem [16];
  logic [31:0] q0_r, q1_r;
  logic        wr_en;
  logic [3:0]  wr_addr, rd_addr0, rd_addr1;
  logic [31:0] wr_data;

  logic [31:0] chain_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] x_r;
  logic [31:0] word_r, word_nxt;
  logic [5:0]  pos_r;
  logic [63:0] bitcnt_r;
  logic [6:0]  round_r;
  logic        pad_first_r;
  logic        out_valid_r;
  logic [159:0] out_data_r;

  logic        put_en;
  logic [7:0]  put_byte;
  logic        in_fire, done_fire;
  logic [31:0] w_cur, f_cur, k_cur, tmp_cur;

  assign in_fire   = in_tvalid && in_tready;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser && pos_r == LAST_POS) begin
            state_nxt = ST_C_START;
            ret_nxt   = in_tlast ? ST_PAD : ST_IDLE;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_first_r || pos_r != LEN_POS) begin
          if (pos_r == LAST_POS) begin
            state_nxt = ST_C_START;
            ret_nxt   = ST_PAD;
          end
        end else begin
          state_nxt = ST_LEN_HI;
        end
      end
      ST_LEN_HI: state_nxt = ST_LEN_LO;
      ST_LEN_LO: begin
        state_nxt = ST_C_START;
        ret_nxt   = ST_DONE;
      end
      ST_C_START: state_nxt = ST_C_B;
      ST_C_B:     state_nxt = ST_C_C;
      ST_C_C:     state_nxt = (round_r == LAST_ROUND) ? ST_C_FIN : ST_C_B;
      ST_C_FIN:   state_nxt = ret_r;
      ST_DONE:    if (done_fire) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory port control.
  always_comb begin
    in_tready = 1'b0;
    put_en    = 1'b0;
    put_byte  = in_tdata;
    wr_en     = 1'b0;
    wr_addr   = pos_r[5:2];
    wr_data   = word_nxt;
    rd_addr0  = round_r[3:0] + 4'd14;
    rd_addr1  = round_r[3:0] + 4'd9;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        put_en    = in_tvalid && in_tuser;
      end
      ST_PAD: begin
        put_en   = pad_first_r || (pos_r != LEN_POS);
        put_byte = pad_first_r ? PAD_MARK : 8'h00;
      end
      ST_LEN_HI: begin
        wr_en   = 1'b1;
        wr_addr = LEN_HI_IDX;
        wr_data = bitcnt_r[63:32];
      end
      ST_LEN_LO: begin
        wr_en   = 1'b1;
        wr_addr = LEN_LO_IDX;
        wr_data = bitcnt_r[31:0];
      end
      ST_C_START: begin
        // pair A of round 0: schedule taps, unused below round 16
        rd_addr0 = 4'd13;
        rd_addr1 = 4'd8;
      end
      ST_C_B: begin
        rd_addr0 = round_r[3:0] + 4'd2;
        rd_addr1 = round_r[3:0];
      end
      ST_C_C: begin
        // write this round's word, issue pair A of the next round
        wr_en   = 1'b1;
        wr_addr = round_r[3:0];
        wr_data = w_cur;
      end
      ST_C_FIN, ST_DONE: ;
      default: ;
    endcase
    if (put_en) wr_en = 1'b1;
  end

  // Byte packing: a new word starts with its top byte.
  always_comb begin
    unique case (pos_r[1:0])
      2'd0: word_nxt = {put_byte, 24'h000000};
      2'd1: word_nxt = word_r | {8'h00, put_byte, 16'h0000};
      2'd2: word_nxt = word_r | {16'h0000, put_byte, 8'h00};
      2'd3: word_nxt = word_r | {24'h000000, put_byte};
      default: word_nxt = word_r;
    endcase
  end

  // Round function.
  always_comb begin
    w_cur = (round_r < 7'd16) ? q1_r : rotl1(x_r ^ q0_r ^ q1_r);
    if (round_r < 7'd20) begin
      f_cur = (b_r & c_r) | (~b_r & d_r);
      k_cur = K0;
    end else if (round_r < 7'd40) begin
      f_cur = b_r ^ c_r ^ d_r;
      k_cur = K1;
    end else if (round_r < 7'd60) begin
      f_cur = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_cur = K2;
    end else begin
      f_cur = b_r ^ c_r ^ d_r;
      k_cur = K3;
    end
    tmp_cur = rotl5(a_r) + f_cur + e_r + k_cur + w_cur;
  end

  always_ff @(posedge clk) begin
    if (wr_en) blk_mem[wr_addr] <= wr_data;
    q0_r <= blk_mem[rd_addr0];
    q1_r <= blk_mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      pos_r       <= '0;
      bitcnt_r    <= '0;
      round_r     <= '0;
      pad_first_r <= 1'b0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= IV0;
      chain_r[1]  <= IV1;
      chain_r[2]  <= IV2;
      chain_r[3]  <= IV3;
      chain_r[4]  <= IV4;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (put_en) pos_r <= pos_r + 6'd1;
      if (state_r == ST_IDLE && put_en) bitcnt_r <= bitcnt_r + 64'd8;
      if (state_r == ST_IDLE && in_fire && in_tlast) pad_first_r <= 1'b1;
      else if (state_r == ST_PAD && put_en) pad_first_r <= 1'b0;
      if (state_r == ST_C_START) round_r <= '0;
      else if (state_r == ST_C_C && round_r != LAST_ROUND) round_r <= round_r + 7'd1;
      if (state_r == ST_C_FIN) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
        pos_r       <= '0;
        bitcnt_r    <= '0;
        chain_r[0]  <= IV0;
        chain_r[1]  <= IV1;
        chain_r[2]  <= IV2;
        chain_r[3]  <= IV3;
        chain_r[4]  <= IV4;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    if (put_en) word_r <= word_nxt;
    if (state_r == ST_C_B) x_r <= q0_r ^ q1_r;
    if (state_r == ST_C_START) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (state_r == ST_C_C) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= rotl30(b_r);
      b_r <= a_r;
      a_r <= tmp_cur;
    end
    if (done_fire) out_data_r <= {chain_r[4], chain_r[3], chain_r[2], chain_r[1], chain_r[0]};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SMD_ASSERT_NOW(a_round_range, (state_r == ST_C_B || state_r == ST_C_C), (round_r <= LAST_ROUND), "round counter out of range")
  `SMD_ASSERT_NOW(a_len_pos, (state_r == ST_LEN_HI), (pos_r == LEN_POS), "length written at wrong byte position")
  `SMD_ASSERT_NEXT(a_comp_start, (state_r == ST_C_START), (state_r == ST_C_B && round_r == 7'd0), "compression did not start at round 0")

endmodule
